// ===== rtl/core/tsac_pkg.sv =====
// Shared constants, codes and control types for the touch averaging block.
`timescale 1ns / 1ps

package tsac_pkg;

  // Session shape
  localparam int unsigned SAMPLES       = 8;
  localparam int unsigned LEFT_W        = 8;
  localparam int unsigned INVALID_LIMIT = 20;
  localparam int unsigned RUN_W         = 5;

  // Field widths
  localparam int unsigned HIGH_W  = 7;
  localparam int unsigned LOW_W   = 8;
  localparam int unsigned AXIS_W  = 10;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned OUT_W   = 15;
  localparam int unsigned MINY_W  = 10;

  // Calibration arithmetic: 32 x 11 signed products, sum of three terms
  localparam int unsigned PROD_W  = COEF_W + AXIS_W + 1;
  localparam int unsigned NUM_W   = PROD_W + 2;
  localparam int unsigned REM_W   = COEF_W - 1;
  localparam int unsigned STEP_W  = $clog2(NUM_W);
  localparam logic [OUT_W-1:0] DISPLAY_MAX = {OUT_W{1'b1}};

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_F  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y   = CFG_IDX_W'(7);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_AVG,
    OP_UPD_AVG,
    OP_MUL_X,
    OP_MUL_Y,
    OP_SUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_STORE,
    OP_OUT_ZERO,
    OP_OUT_CALC
  } tsac_op_e;

  typedef struct packed {
    tsac_op_e op;
    logic     axis;  // 0: display x, 1: display y
  } tsac_cmd_t;

  typedef struct packed {
    logic reading_valid;
    logic avg_zero;
  } tsac_stat_t;

endpackage

// ===== rtl/core/touch_sample_average_calibrate.sv =====
// Top level of the touch sample averaging and calibration block.
//
//   channel  signals                                      direction
//   in       in_valid_i/in_ready_o, x_high_i..y_low_i     reading request in
//   out      out_valid_o/out_ready_i, display_*, touched  point request out
//   cfg      cfg_valid_i/cfg_ready_o, cfg_index_i/data_i  register write in
//
// A reading that does not end a session leaves the input ready. A reading that
// ends a session keeps the input busy through a check state, two passes
// (multiply, add, 45-step serial divide, store), one per display axis, and an
// output state. A reading rejected while idle, or a session that ends with no
// valid point, goes straight to the output state for its zero point, as does a
// zero average found by the check state. rst_ni clears control state, config
// and averages asynchronously; no clearing pass is needed. Arithmetic and
// output data registers are not reset. A pending result waits in the output
// register; new requests are still taken, and the next result and the input
// wait for it to drain. Config is always ready.
`timescale 1ns / 1ps

module touch_sample_average_calibrate import tsac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HIGH_W-1:0]    x_high_i,
  input  logic [LOW_W-1:0]     x_low_i,
  input  logic [HIGH_W-1:0]    y_high_i,
  input  logic [LOW_W-1:0]     y_low_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     display_x_o,
  output logic [OUT_W-1:0]     display_y_o,
  output logic                 touched_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  tsac_cmd_t  cmd;
  tsac_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tsac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tsac_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .x_high_i    (x_high_i),
    .x_low_i     (x_low_i),
    .y_high_i    (y_high_i),
    .y_low_i     (y_low_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .display_x_o (display_x_o),
    .display_y_o (display_y_o),
    .touched_o   (touched_o)
  );

endmodule

// ===== rtl/core/tsac_ctrl.sv =====
// Session bookkeeping and sequencing of the calibration datapath.
`timescale 1ns / 1ps

module tsac_ctrl import tsac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  tsac_stat_t stat_i,
  output tsac_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_X,
    S_MUL_Y,
    S_SUM,
    S_DIV_INIT,
    S_DIV,
    S_STORE,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic               in_session_q;
  logic [LEFT_W-1:0]  left_q;
  logic [RUN_W-1:0]   run_q;
  logic [STEP_W-1:0]  step_q;
  logic               axis_q;
  logic               zero_q;
  logic               out_valid_q;

  logic               accept;
  logic               out_free;
  logic [LEFT_W-1:0]  left_d;
  logic [RUN_W-1:0]   run_d;
  logic               sess_end;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    left_d = left_q - LEFT_W'(1);
    if (stat_i.reading_valid) begin
      run_d = '0;
    end else if (run_q < RUN_W'(INVALID_LIMIT)) begin
      run_d = run_q + RUN_W'(1);
    end else begin
      run_d = run_q;
    end
    sess_end = (run_d >= RUN_W'(INVALID_LIMIT)) || (left_d == '0);
  end

  always_comb begin
    cmd_o.axis = axis_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept && stat_i.reading_valid) begin
          cmd_o.op = in_session_q ? OP_UPD_AVG : OP_LOAD_AVG;
        end
      end
      S_MUL_X:    cmd_o.op = OP_MUL_X;
      S_MUL_Y:    cmd_o.op = OP_MUL_Y;
      S_SUM:      cmd_o.op = OP_SUM;
      S_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIV:      cmd_o.op = OP_DIV_STEP;
      S_STORE:    cmd_o.op = OP_STORE;
      S_EMIT: begin
        if (out_free) begin
          cmd_o.op = zero_q ? OP_OUT_ZERO : OP_OUT_CALC;
        end
      end
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_session_q <= 1'b0;
      left_q       <= '0;
      run_q        <= '0;
      step_q       <= '0;
      axis_q       <= 1'b0;
      zero_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // in S_EMIT the output register is refilled or still held
      if (out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!in_session_q) begin
              if (stat_i.reading_valid) begin
                in_session_q <= 1'b1;
                left_q       <= LEFT_W'(SAMPLES);
                run_q        <= '0;
              end else begin
                zero_q  <= 1'b1;
                state_q <= S_EMIT;
              end
            end else if (sess_end) begin
              in_session_q <= 1'b0;
              left_q       <= '0;
              run_q        <= '0;
              if (run_d == '0) begin
                state_q <= S_CHECK;
              end else begin
                zero_q  <= 1'b1;
                state_q <= S_EMIT;
              end
            end else begin
              left_q <= left_d;
              run_q  <= run_d;
            end
          end
        end
        S_CHECK: begin
          axis_q <= 1'b0;
          if (stat_i.avg_zero) begin
            zero_q  <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            zero_q  <= 1'b0;
            state_q <= S_MUL_X;
          end
        end
        S_MUL_X: state_q <= S_MUL_Y;
        S_MUL_Y: state_q <= S_SUM;
        S_SUM:   state_q <= S_DIV_INIT;
        S_DIV_INIT: begin
          step_q  <= STEP_W'(NUM_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            state_q <= S_STORE;
          end
        end
        S_STORE: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= S_MUL_X;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/tsac_datapath.sv =====
// Configuration registers, averaging, multiply/accumulate, serial divider and result registers.
`timescale 1ns / 1ps

module tsac_datapath import tsac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  input  logic [HIGH_W-1:0]    x_high_i,
  input  logic [LOW_W-1:0]     x_low_i,
  input  logic [HIGH_W-1:0]    y_high_i,
  input  logic [LOW_W-1:0]     y_low_i,
  input  tsac_cmd_t            cmd_i,
  output tsac_stat_t           stat_o,
  output logic [OUT_W-1:0]     display_x_o,
  output logic [OUT_W-1:0]     display_y_o,
  output logic                 touched_o
);

  logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
  logic signed [COEF_W-1:0] coef_d_q, coef_e_q, coef_f_q;
  logic signed [COEF_W-1:0] divider_q;
  logic [MINY_W-1:0]        min_y_q;

  logic [AXIS_W-1:0]        avg_x_q, avg_y_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]         quo_q;
  logic [REM_W-1:0]         rem_q;
  logic [COEF_W-1:0]        dmag_q;
  logic                     neg_q;
  logic [OUT_W-1:0]         res_x_q, res_y_q;
  logic [OUT_W-1:0]         disp_x_q, disp_y_q;
  logic                     touched_q;

  logic [AXIS_W-1:0]        x10, y10;
  logic signed [COEF_W-1:0] wx, wy, off;
  logic signed [PROD_W-1:0] mul_a, mul_b;
  logic [AXIS_W-1:0]        mul_opd;
  logic [COEF_W-1:0]        rem_sh;
  logic                     rem_ge;
  logic [OUT_W-1:0]         res_d;

  // 12-bit reading keeps the top five bits of the low byte; drop two more.
  // Inverting y: (4095 - y12) >> 2 is the complement of the top ten bits.
  assign x10 = {x_high_i, x_low_i[LOW_W-1 -: AXIS_W-HIGH_W]};
  assign y10 = ~{y_high_i, y_low_i[LOW_W-1 -: AXIS_W-HIGH_W]};

  assign stat_o.reading_valid = (y10 >= min_y_q);
  assign stat_o.avg_zero      = (avg_x_q == '0) || (avg_y_q == '0);

  always_comb begin
    wx  = cmd_i.axis ? coef_d_q : coef_a_q;
    wy  = cmd_i.axis ? coef_e_q : coef_b_q;
    off = cmd_i.axis ? coef_f_q : coef_c_q;
  end

  // One shared 32 x 11 signed multiplier
  always_comb begin
    mul_opd = (cmd_i.op == OP_MUL_X) ? avg_x_q : avg_y_q;
    mul_a   = PROD_W'((cmd_i.op == OP_MUL_X) ? wx : wy);
    mul_b   = PROD_W'($signed({1'b0, mul_opd}));
  end

  // Restoring divider on magnitudes, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    rem_ge = (rem_sh >= dmag_q);
  end

  always_comb begin
    if ((divider_q == '0) || neg_q) begin
      res_d = '0;
    end else if (|quo_q[NUM_W-1:OUT_W]) begin
      res_d = DISPLAY_MAX;
    end else begin
      res_d = quo_q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q  <= COEF_W'(1);
      coef_b_q  <= '0;
      coef_c_q  <= '0;
      coef_d_q  <= '0;
      coef_e_q  <= COEF_W'(1);
      coef_f_q  <= '0;
      divider_q <= COEF_W'(1);
      min_y_q   <= '0;
      avg_x_q   <= '0;
      avg_y_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_COEF_A:  coef_a_q  <= cfg_data_i;
          REG_COEF_B:  coef_b_q  <= cfg_data_i;
          REG_COEF_C:  coef_c_q  <= cfg_data_i;
          REG_COEF_D:  coef_d_q  <= cfg_data_i;
          REG_COEF_E:  coef_e_q  <= cfg_data_i;
          REG_COEF_F:  coef_f_q  <= cfg_data_i;
          REG_DIVIDER: divider_q <= cfg_data_i;
          REG_MIN_Y:   min_y_q   <= cfg_data_i[MINY_W-1:0];
          default:     ;
        endcase
      end
      if (cmd_i.op == OP_LOAD_AVG) begin
        avg_x_q <= x10;
        avg_y_q <= y10;
      end else if (cmd_i.op == OP_UPD_AVG) begin
        avg_x_q <= AXIS_W'(({1'b0, avg_x_q} + {1'b0, x10}) >> 1);
        avg_y_q <= AXIS_W'(({1'b0, avg_y_q} + {1'b0, y10}) >> 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MUL_X: prod_q <= mul_a * mul_b;
      OP_MUL_Y: begin
        num_q  <= NUM_W'(prod_q) + NUM_W'(off);
        prod_q <= mul_a * mul_b;
      end
      OP_SUM: num_q <= num_q + NUM_W'(prod_q);
      OP_DIV_INIT: begin
        neg_q  <= num_q[NUM_W-1] ^ divider_q[COEF_W-1];
        quo_q  <= num_q[NUM_W-1] ? (~num_q + NUM_W'(1)) : num_q;
        dmag_q <= divider_q[COEF_W-1] ? (~divider_q + COEF_W'(1)) : divider_q;
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_ge ? REM_W'(rem_sh - dmag_q) : rem_sh[REM_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], rem_ge};
      end
      OP_STORE: begin
        if (cmd_i.axis) begin
          res_y_q <= res_d;
        end else begin
          res_x_q <= res_d;
        end
      end
      OP_OUT_ZERO: begin
        disp_x_q  <= '0;
        disp_y_q  <= '0;
        touched_q <= 1'b0;
      end
      OP_OUT_CALC: begin
        disp_x_q  <= res_x_q;
        disp_y_q  <= res_y_q;
        touched_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign display_x_o = disp_x_q;
  assign display_y_o = disp_y_q;
  assign touched_o   = touched_q;

endmodule
